// ===== design/cst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg: shared types and constants of the counting semaphore table
// Table geometry, action and status codes, entry word layout, ring helpers
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int NUM_SEMS    = 64;
  localparam int ID_W        = 6;
  localparam int QUEUE_SLOTS = 8;
  localparam int QPTR_W      = $clog2(QUEUE_SLOTS);
  localparam int PID_W       = 8;
  localparam int COUNT_W     = 16;
  localparam int ACT_W       = 3;
  localparam int STAT_W      = 3;
  localparam int SLOT_ADDR_W = $clog2(NUM_SEMS * QUEUE_SLOTS);

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;

  localparam logic [ACT_W-1:0] ACT_ALLOC   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_WAIT    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SIGNAL  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_TRYTAKE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_BLOCKED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NONE_FREE = 3'd3;
  localparam logic [STAT_W-1:0] ST_WOKEN     = 3'd4;

  typedef struct packed {
    logic signed [COUNT_W-1:0] count;
    logic [QPTR_W-1:0]         head;
    logic [QPTR_W-1:0]         tail;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic pop_read;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_pop;
  } dp_stat_t;

  function automatic logic [QPTR_W-1:0] ring_next(logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_SLOTS - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [SLOT_ADDR_W-1:0] slot_addr(logic [ID_W-1:0] id,
                                                       logic [QPTR_W-1:0] p);
    return SLOT_ADDR_W'(id) * SLOT_ADDR_W'(QUEUE_SLOTS) + SLOT_ADDR_W'(p);
  endfunction

endpackage

// ===== design/cst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ctrl: request sequencer of the counting semaphore table
// Accepts one transaction, steps it through entry read, optional waiter
// read and commit, and owns the output valid flag.
// ----------------------------------------------------------------------------
module cst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  cst_pkg::dp_stat_t stat,
  output cst_pkg::ctl_cmd_t cmd
);
  import cst_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.accept   = 1'b0;
    cmd.pop_read = 1'b0;
    cmd.finish   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.need_pop) begin
          cmd.pop_read = 1'b1;
          state_next   = S_POP;
        end else if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_POP: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/cst_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_dp: datapath of the counting semaphore table
// Holds the in-use flags, the entry memory (count and ring pointers), the
// waiter memory, the free-entry encoder and the result registers.
// ----------------------------------------------------------------------------
module cst_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  cst_pkg::ctl_cmd_t             cmd,
  output cst_pkg::dp_stat_t             stat,
  input  logic [cst_pkg::ACT_W-1:0]     action,
  input  logic [cst_pkg::ID_W-1:0]      sem_id,
  input  logic signed [cst_pkg::COUNT_W-1:0] initial_value,
  input  logic [cst_pkg::PID_W-1:0]     pid,
  output logic [cst_pkg::STAT_W-1:0]    status,
  output logic [cst_pkg::ID_W-1:0]      granted_id,
  output logic [cst_pkg::PID_W-1:0]     woken_pid
);
  import cst_pkg::*;

  entry_t ent_mem [NUM_SEMS];
  logic [PID_W-1:0] pid_mem [NUM_SEMS * QUEUE_SLOTS];

  logic [NUM_SEMS-1:0]       in_use;
  logic [ACT_W-1:0]          req_action;
  logic [ID_W-1:0]           req_id;
  logic signed [COUNT_W-1:0] req_init;
  logic [PID_W-1:0]          req_pid;
  entry_t                    ent_rd;
  logic [PID_W-1:0]          pid_rd;

  logic [QPTR_W-1:0] head_next;
  logic [QPTR_W-1:0] tail_next;
  logic              q_empty;
  logic              q_full;
  logic              free_found;
  logic [ID_W-1:0]   free_idx;

  logic [STAT_W-1:0]     res_status;
  logic [ID_W-1:0]       res_granted;
  logic [PID_W-1:0]      res_woken;
  logic                  ent_we;
  logic [ID_W-1:0]       ent_waddr;
  entry_t                ent_wdata;
  logic                  pid_we;
  logic                  use_set;
  logic                  use_clr;

  assign head_next     = ring_next(ent_rd.head);
  assign tail_next     = ring_next(ent_rd.tail);
  assign q_empty       = (ent_rd.head == ent_rd.tail);
  assign q_full        = (tail_next == ent_rd.head);
  assign stat.need_pop = (req_action == ACT_SIGNAL) && !q_empty;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SEMS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = ID_W'(i);
      end
    end
  end

  always_comb begin
    res_status  = ST_OK;
    res_granted = '0;
    res_woken   = '0;
    ent_we      = 1'b0;
    ent_waddr   = req_id;
    ent_wdata   = ent_rd;
    pid_we      = 1'b0;
    use_set     = 1'b0;
    use_clr     = 1'b0;
    unique case (req_action)
      ACT_ALLOC: begin
        if (free_found) begin
          use_set         = 1'b1;
          ent_we          = 1'b1;
          ent_waddr       = free_idx;
          ent_wdata.count = req_init;
          ent_wdata.head  = '0;
          ent_wdata.tail  = '0;
          res_granted     = free_idx;
        end else begin
          res_status = ST_NONE_FREE;
        end
      end
      ACT_WAIT: begin
        if (q_full) begin
          res_status = ST_FULL;
        end else if (ent_rd.count <= 0) begin
          pid_we         = 1'b1;
          ent_we         = 1'b1;
          ent_wdata.tail = tail_next;
          res_status     = ST_BLOCKED;
        end else begin
          ent_we          = 1'b1;
          ent_wdata.count = ent_rd.count - COUNT_W'(1);
        end
      end
      ACT_SIGNAL: begin
        if (!q_empty) begin
          ent_we         = 1'b1;
          ent_wdata.head = head_next;
          res_woken      = pid_rd;
          res_status     = ST_WOKEN;
        end else if (ent_rd.count < COUNT_MAX) begin
          ent_we          = 1'b1;
          ent_wdata.count = ent_rd.count + COUNT_W'(1);
        end
      end
      ACT_TRYTAKE: begin
        if (ent_rd.count > 0) begin
          ent_we          = 1'b1;
          ent_wdata.count = ent_rd.count - COUNT_W'(1);
        end
      end
      ACT_RELEASE: begin
        use_clr = 1'b1;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_action <= action;
      req_id     <= sem_id;
      req_init   <= initial_value;
      req_pid    <= pid;
      ent_rd     <= ent_mem[sem_id];
    end
    if (cmd.pop_read) begin
      pid_rd <= pid_mem[slot_addr(req_id, ent_rd.head)];
    end
    if (cmd.finish) begin
      status     <= res_status;
      granted_id <= res_granted;
      woken_pid  <= res_woken;
      if (ent_we) begin
        ent_mem[ent_waddr] <= ent_wdata;
      end
      if (pid_we) begin
        pid_mem[slot_addr(req_id, ent_rd.tail)] <= req_pid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (cmd.finish) begin
      if (use_set) begin
        in_use[free_idx] <= 1'b1;
      end else if (use_clr) begin
        in_use[req_id] <= 1'b0;
      end
    end
  end

endmodule

// ===== design/counting_semaphore_table.sv =====
// Sequence: an accepted request reads its entry; a signal that pops a waiter
// also reads the waiter memory; the result is registered at commit, which
// waits while a stalled result is held. A new request is taken only after
// the current one commits; the output register frees the input.
// Reset: synchronous; clears the in-use flags, sequencer and output valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_table: table of counting semaphores with wait queues
// Allocate, wait, signal, try take and release on 64 entries, each with a
// count and a ring of waiting process ids.
// ----------------------------------------------------------------------------
module counting_semaphore_table (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cst_pkg::ACT_W-1:0]          action,
  input  logic [cst_pkg::ID_W-1:0]           sem_id,
  input  logic signed [cst_pkg::COUNT_W-1:0] initial_value,
  input  logic [cst_pkg::PID_W-1:0]          pid,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cst_pkg::STAT_W-1:0]         status,
  output logic [cst_pkg::ID_W-1:0]           granted_id,
  output logic [cst_pkg::PID_W-1:0]          woken_pid
);
  import cst_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  cst_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .action        (action),
    .sem_id        (sem_id),
    .initial_value (initial_value),
    .pid           (pid),
    .status        (status),
    .granted_id    (granted_id),
    .woken_pid     (woken_pid)
  );

endmodule

// ===== design/cst_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker: port-level checks of the counting semaphore table
// Watches the handshake and result fields of the top level over time.
// ----------------------------------------------------------------------------
module cst_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [cst_pkg::ACT_W-1:0]          action,
  input logic [cst_pkg::ID_W-1:0]           sem_id,
  input logic signed [cst_pkg::COUNT_W-1:0] initial_value,
  input logic [cst_pkg::PID_W-1:0]          pid,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [cst_pkg::STAT_W-1:0]         status,
  input logic [cst_pkg::ID_W-1:0]           granted_id,
  input logic [cst_pkg::PID_W-1:0]          woken_pid
);
  import cst_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)
      && $stable(granted_id) && $stable(woken_pid))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("second transaction taken while one is in flight");

  a_result_timing: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_xfer, 2) || $past(in_xfer, 3))
    else $error("result without matching transaction");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || granted_id == '0)
      && (status == ST_WOKEN || woken_pid == '0))
    else $error("unused result field not zero");

endmodule

bind counting_semaphore_table cst_checker u_cst_checker (.*);
